@@ src/med_pkg.sv @@
// Shared types, codes and constant tables of the MIDI event decoder.
package med_pkg;

	// Number of FM channels served by the decoder and the channel map depth.
	localparam int FM_CHANNELS = 6;
	localparam int MAP_REGS    = 6;
	localparam int MAP_SEARCH  = (FM_CHANNELS < MAP_REGS) ? FM_CHANNELS : MAP_REGS;

	// Width of the packed result item on the output stream.
	localparam int RES_BITS   = 53;
	localparam int TDATA_BITS = ((RES_BITS + 7) / 8) * 8;

	// Configuration register indexes.
	localparam logic [2:0] REG_MAP_0      = 3'd0;
	localparam logic [2:0] REG_MAP_5      = 3'd5;
	localparam logic [2:0] REG_VOICE_MODE = 3'd6;

	// Parser phase.
	typedef enum logic [1:0] {
		PH_WAIT  = 2'd0,
		PH_DATA1 = 2'd1,
		PH_DATA2 = 2'd2
	} phase_t;

	// Event codes.
	typedef enum logic [3:0] {
		EV_NONE     = 4'd0,
		EV_PLAY     = 4'd1,
		EV_RELEASE  = 4'd2,
		EV_CHAN_PAR = 4'd3,
		EV_GLOB_PAR = 4'd4,
		EV_OP_PAR   = 4'd5,
		EV_BEND     = 4'd6,
		EV_ALL_OFF  = 4'd7,
		EV_CLOCK    = 4'd8,
		EV_START    = 4'd9,
		EV_BANK     = 4'd10
	} event_t;

	// Voice modes.
	localparam logic [1:0] VM_POLY   = 2'd0;
	localparam logic [1:0] VM_INDEP  = 2'd1;

	// MIDI status commands (upper nibble).
	localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
	localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
	localparam logic [3:0] CMD_CTRL     = 4'hB;
	localparam logic [3:0] CMD_PROGRAM  = 4'hC;
	localparam logic [3:0] CMD_BEND     = 4'hE;
	localparam logic [3:0] CMD_SYSTEM   = 4'hF;

	// Realtime bytes.
	localparam logic [7:0] RT_FIRST = 8'hF8;
	localparam logic [7:0] RT_CLOCK = 8'hF8;
	localparam logic [7:0] RT_START = 8'hFA;
	localparam logic [7:0] RT_STOP  = 8'hFC;

	// Controller numbers.
	localparam logic [6:0] CC_BANK      = 7'd0;
	localparam logic [6:0] CC_DATA      = 7'd6;
	localparam logic [6:0] CC_NRPN_LSB  = 7'd98;
	localparam logic [6:0] CC_NRPN_MSB  = 7'd99;
	localparam logic [6:0] CC_ALL_OFF   = 7'h7B;
	localparam logic [6:0] CC_RESET_ALL = 7'h79;

	// Highest clock tick count; the tick counter wraps to zero after it.
	localparam logic [4:0] TICK_MAX = 5'd24;

	// One result item.
	typedef struct packed {
		logic [4:0]  clock_count;
		logic [13:0] bend_value;
		logic [6:0]  param_value;
		logic [1:0]  operator_index;
		logic [3:0]  param_id;
		logic        resend_patch;
		logic [5:0]  flash_mask;
		logic [6:0]  note_number;
		logic [2:0]  fm_channel;
		logic [3:0]  event_res;
	} result_t;

	// Value mask of the channel parameters 0 to 4.
	function automatic logic [6:0] chan_mask(input logic [2:0] n);
		logic [6:0] m;
		case (n)
			3'd2, 3'd4: m = 7'd3;
			default:    m = 7'd7;
		endcase
		return m;
	endfunction

	// Right shift applied to each operator parameter value.
	function automatic logic [2:0] op_shift(input logic [3:0] pr);
		logic [2:0] s;
		case (pr)
			4'd2, 4'd3, 4'd4:       s = 3'd2;
			4'd5, 4'd6, 4'd8:       s = 3'd3;
			4'd7:                   s = 3'd5;
			4'd9:                   s = 3'd4;
			default:                s = 3'd0;
		endcase
		return s;
	endfunction

endpackage

@@ src/midi_event_decoder.sv @@
// MIDI event decoder: turns a MIDI byte stream into FM synthesiser events.
//
// The decoder accepts one MIDI byte per item on the s_ side and returns exactly one event
// item per byte on the m_ side (event_res 0 when the byte completes nothing). A byte is
// registered in the input stage on acceptance, decoded there against the parser state and
// written to the output register, and a new byte is taken every cycle while the output
// register is free or being emptied; the only limit on rate is back-pressure from m_tready.
// Channel status bytes are matched against the six channel map registers (lowest FM
// channel wins), realtime bytes are handled at once without disturbing a pending message,
// and there is no running status. Configuration writes are always ready and take effect
// at once; they are meant to be made while the decoder is idle.
module midi_event_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input stream. s_tdata: midi_byte [7:0].
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,
	// Output stream. m_tdata: event_res [3:0], fm_channel [6:4], note_number [13:7],
	// flash_mask [19:14], resend_patch [20], param_id [24:21], operator_index [26:25],
	// param_value [33:27], bend_value [47:34], clock_count [52:48], zeros above.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [med_pkg::TDATA_BITS-1:0]   m_tdata,
	// Configuration write channel.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [2:0]                       cfg_index,
	input  logic [3:0]                       cfg_data
);

	// Configuration registers.
	logic [3:0] chan_map_q [med_pkg::MAP_REGS];
	logic [1:0] voice_mode_q;

	// Parser state.
	med_pkg::phase_t phase_q, phase_d;
	logic [3:0] pend_cmd_q, pend_cmd_d;
	logic [3:0] pend_midi_q, pend_midi_d;
	logic [2:0] pend_fm_q, pend_fm_d;
	logic [6:0] first_q, first_d;
	logic [2:0] rotate_q, rotate_d;
	logic [6:0] nrpn_low_q, nrpn_low_d;
	logic [6:0] nrpn_high_q, nrpn_high_d;
	logic [2:0] unison_q, unison_d;
	logic [4:0] tick_q, tick_d;

	// Input stage and output register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_valid_q;
	med_pkg::result_t res_q, res_d;
	logic       advance;

	// Handshakes: the input stage moves on whenever the output register can take a result.
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {{(med_pkg::TDATA_BITS - med_pkg::RES_BITS){1'b0}}, res_q};
	assign cfg_ready = 1'b1;

	// Configuration writes; indexes past the voice mode are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < med_pkg::MAP_REGS; i++) begin
				chan_map_q[i] <= 4'(i);
			end
			voice_mode_q <= med_pkg::VM_INDEP;
		end else if (cfg_valid) begin
			if (cfg_index <= med_pkg::REG_MAP_5) begin
				chan_map_q[cfg_index - med_pkg::REG_MAP_0] <= cfg_data;
			end else if (cfg_index == med_pkg::REG_VOICE_MODE) begin
				voice_mode_q <= cfg_data[1:0];
			end
		end
	end

	// Decode of the byte in the input stage.
	always_comb begin
		logic [3:0] cmd;
		logic [3:0] ch;
		logic       found;
		logic [2:0] found_ch;
		logic       master;
		logic [6:0] val;
		logic [3:0] slot;
		logic [3:0] next_slot;
		logic [6:0] nm;
		logic [1:0] op;
		logic [3:0] pr;

		phase_d     = phase_q;
		pend_cmd_d  = pend_cmd_q;
		pend_midi_d = pend_midi_q;
		pend_fm_d   = pend_fm_q;
		first_d     = first_q;
		rotate_d    = rotate_q;
		nrpn_low_d  = nrpn_low_q;
		nrpn_high_d = nrpn_high_q;
		unison_d    = unison_q;
		tick_d      = tick_q;
		res_d       = '0;

		cmd    = byte_s1[7:4];
		ch     = byte_s1[3:0];
		val    = byte_s1[6:0];
		master = (pend_midi_q == chan_map_q[0]);

		// Lowest FM channel whose map entry matches the status channel.
		found    = 1'b0;
		found_ch = '0;
		for (int c = med_pkg::MAP_SEARCH - 1; c >= 0; c--) begin
			if (chan_map_q[c] == ch) begin
				found    = 1'b1;
				found_ch = 3'(c);
			end
		end

		// Poly slot rotation.
		slot      = ({1'b0, rotate_q} >= 4'(med_pkg::FM_CHANNELS)) ? 4'd0 : {1'b0, rotate_q};
		next_slot = slot + 4'd1;
		if (next_slot >= 4'(med_pkg::FM_CHANNELS)) begin
			next_slot = 4'd0;
		end

		// Operator parameter number split into operator and parameter.
		nm = nrpn_low_q - 7'd10;
		if (nrpn_low_q < 7'd20) begin
			op = 2'd0;
			pr = 4'(nm);
		end else if (nrpn_low_q < 7'd30) begin
			op = 2'd1;
			pr = 4'(nm - 7'd10);
		end else if (nrpn_low_q < 7'd40) begin
			op = 2'd2;
			pr = 4'(nm - 7'd20);
		end else begin
			op = 2'd3;
			pr = 4'(nm - 7'd30);
		end

		if (byte_s1[7]) begin
			if (byte_s1 >= med_pkg::RT_FIRST) begin
				// Realtime bytes leave any pending message alone.
				if (byte_s1 == med_pkg::RT_CLOCK) begin
					tick_d          = (tick_q < med_pkg::TICK_MAX) ? tick_q + 5'd1 : 5'd0;
					res_d.event_res = med_pkg::EV_CLOCK;
				end else if (byte_s1 == med_pkg::RT_START) begin
					tick_d          = '0;
					res_d.event_res = med_pkg::EV_START;
				end else if (byte_s1 == med_pkg::RT_STOP) begin
					res_d.event_res = med_pkg::EV_ALL_OFF;
				end
			end else begin
				// Any other status byte starts over.
				phase_d = med_pkg::PH_WAIT;
				if (cmd != med_pkg::CMD_SYSTEM && found &&
						(cmd == med_pkg::CMD_NOTE_OFF || cmd == med_pkg::CMD_NOTE_ON ||
						 cmd == med_pkg::CMD_CTRL || cmd == med_pkg::CMD_PROGRAM ||
						 cmd == med_pkg::CMD_BEND)) begin
					pend_cmd_d  = cmd;
					pend_midi_d = ch;
					pend_fm_d   = found_ch;
					phase_d     = med_pkg::PH_DATA1;
				end
			end
		end else begin
			unique case (phase_q)
				med_pkg::PH_DATA1: begin
					if (pend_cmd_q == med_pkg::CMD_PROGRAM) begin
						phase_d = med_pkg::PH_WAIT;
					end else begin
						first_d = val;
						phase_d = med_pkg::PH_DATA2;
					end
				end
				med_pkg::PH_DATA2: begin
					phase_d = med_pkg::PH_WAIT;
					case (pend_cmd_q)
						med_pkg::CMD_NOTE_ON: begin
							if (voice_mode_q == med_pkg::VM_POLY) begin
								if (master) begin
									rotate_d          = next_slot[2:0];
									res_d.event_res   = med_pkg::EV_PLAY;
									res_d.fm_channel  = slot[2:0];
									res_d.note_number = first_q;
									for (int i = 0; i < 6; i++) begin
										res_d.flash_mask[i] = (slot == 4'(i));
									end
								end
							end else if (voice_mode_q == med_pkg::VM_INDEP) begin
								res_d.event_res   = med_pkg::EV_PLAY;
								res_d.fm_channel  = pend_fm_q;
								res_d.note_number = first_q;
								for (int i = 0; i < 6; i++) begin
									res_d.flash_mask[i] = (pend_fm_q == 3'(i));
								end
							end else if (master) begin
								res_d.event_res   = med_pkg::EV_PLAY;
								res_d.note_number = first_q;
								for (int i = 0; i < 6; i++) begin
									res_d.flash_mask[i] = (4'(i) < {1'b0, unison_q} + 4'd2);
								end
							end
						end
						med_pkg::CMD_NOTE_OFF: begin
							if (voice_mode_q == med_pkg::VM_INDEP) begin
								res_d.event_res   = med_pkg::EV_RELEASE;
								res_d.fm_channel  = pend_fm_q;
								res_d.note_number = first_q;
							end else if (master) begin
								res_d.event_res   = med_pkg::EV_RELEASE;
								res_d.fm_channel  = (voice_mode_q == med_pkg::VM_POLY) ?
									3'd6 : 3'd0;
								res_d.note_number = first_q;
							end
						end
						med_pkg::CMD_CTRL: begin
							res_d.fm_channel   = pend_fm_q;
							res_d.resend_patch = 1'b1;
							if (first_q == med_pkg::CC_BANK && val <= 7'd3) begin
								res_d.event_res   = med_pkg::EV_BANK;
								res_d.param_value = val;
							end
							if (first_q == med_pkg::CC_NRPN_LSB) begin
								nrpn_low_d = val;
							end
							if (first_q == med_pkg::CC_NRPN_MSB) begin
								nrpn_high_d = val;
							end
							if (first_q == med_pkg::CC_DATA && nrpn_high_q == 7'd0) begin
								// Parameter write selected by the NRPN number.
								if (nrpn_low_q <= 7'd4) begin
									res_d.event_res   = med_pkg::EV_CHAN_PAR;
									res_d.param_id    = nrpn_low_q[3:0];
									res_d.param_value = val & med_pkg::chan_mask(nrpn_low_q[2:0]);
								end else if (nrpn_low_q == 7'd5) begin
									res_d.event_res   = med_pkg::EV_GLOB_PAR;
									res_d.param_id    = 4'd5;
									res_d.param_value = val & 7'd7;
								end else if (nrpn_low_q == 7'd6) begin
									res_d.event_res   = med_pkg::EV_GLOB_PAR;
									res_d.param_id    = 4'd6;
									res_d.param_value = val & 7'd1;
								end else if (nrpn_low_q == 7'd7) begin
									res_d.event_res   = med_pkg::EV_GLOB_PAR;
									res_d.param_id    = 4'd7;
									res_d.param_value = val >> 1;
								end else if (nrpn_low_q == 7'd8) begin
									if (val <= 7'd4) begin
										unison_d          = val[2:0];
										res_d.event_res   = med_pkg::EV_GLOB_PAR;
										res_d.param_id    = 4'd8;
										res_d.param_value = val;
									end
								end else if (nrpn_low_q >= 7'd10 && nrpn_low_q < 7'd50) begin
									res_d.event_res      = med_pkg::EV_OP_PAR;
									res_d.param_id       = pr;
									res_d.operator_index = op;
									res_d.param_value    = (pr == 4'd1) ? (val & 7'd1) :
										(val >> med_pkg::op_shift(pr));
								end
							end else if (first_q == med_pkg::CC_ALL_OFF) begin
								res_d.event_res = med_pkg::EV_ALL_OFF;
							end else if (first_q == med_pkg::CC_RESET_ALL) begin
								tick_d = '0;
							end
						end
						med_pkg::CMD_BEND: begin
							// Fourteen-bit bend with the centre moved to zero.
							res_d.event_res  = med_pkg::EV_BEND;
							res_d.fm_channel = pend_fm_q;
							res_d.bend_value = {~val[6], val[5:0], first_q};
						end
						default: begin
						end
					endcase
				end
				default: begin
					phase_d = med_pkg::PH_WAIT;
				end
			endcase
		end

		res_d.clock_count = tick_d;
	end

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// Parser state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= med_pkg::PH_WAIT;
			pend_cmd_q  <= '0;
			pend_midi_q <= '0;
			pend_fm_q   <= '0;
			first_q     <= '0;
			rotate_q    <= '0;
			nrpn_low_q  <= '0;
			nrpn_high_q <= 7'd1;
			unison_q    <= '0;
			tick_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q     <= phase_d;
				pend_cmd_q  <= pend_cmd_d;
				pend_midi_q <= pend_midi_d;
				pend_fm_q   <= pend_fm_d;
				first_q     <= first_d;
				rotate_q    <= rotate_d;
				nrpn_low_q  <= nrpn_low_d;
				nrpn_high_q <= nrpn_high_d;
				unison_q    <= unison_d;
				tick_q      <= tick_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	// A decoded item always lands in the output register.
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("decoded item did not reach the output register");

	// Realtime bytes leave the parser phase untouched.
	a_realtime_keeps_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && byte_s1 >= med_pkg::RT_FIRST) |=> phase_q == $past(phase_q))
		else $error("realtime byte changed the parser phase");

	// The clock tick counter stays within one beat.
	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q <= med_pkg::TICK_MAX)
		else $error("tick count out of range");

	// Only play events carry a flash mask.
	a_flash_on_play: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.event_res != med_pkg::EV_PLAY) |-> res_q.flash_mask == '0)
		else $error("flash mask set on a non-play event");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench of the MIDI event decoder: directed and random byte streams.
module tb_top;

	localparam int         STALL_LIMIT  = 2000;
	localparam int         PHASES       = 6;
	localparam int         PHASE_ITEMS  = 212;
	localparam int         OPEN_LEN     = 31;
	localparam logic [2:0] REG_SPARE    = 3'd7;
	localparam logic [1:0] VM_UNISON    = 2'd2;
	localparam logic [1:0] VM_UNI_MULTI = 2'd3;
	localparam logic [3:0] CMD_POLY_AT  = 4'hA;
	localparam logic [3:0] CMD_CHAN_AT  = 4'hD;
	localparam logic [7:0] SYS_FIRST    = 8'hF0;
	localparam logic [6:0] NRPN_UNISON  = 7'd8;

	// Right shift of each operator parameter, three bits per entry, parameter 0 lowest.
	localparam logic [29:0] OP_SHR = {3'd4, 3'd3, 3'd5, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd0, 3'd0};

	// Opening stream, first byte in the highest bits.
	localparam logic [8*OPEN_LEN-1:0] OPENING = {
		// Extreme notes, a zero velocity that still plays, then a release.
		med_pkg::CMD_NOTE_ON, 4'd0, 8'h00, 8'h7F,
		med_pkg::CMD_NOTE_ON, 4'd5, 8'h7F, 8'h00,
		med_pkg::CMD_NOTE_OFF, 4'd3, 8'h40, 8'h10,
		// Pitch bend at both ends of its range.
		med_pkg::CMD_BEND, 4'd1, 8'h00, 8'h00,
		med_pkg::CMD_BEND, 4'd2, 8'h7F, 8'h7F,
		// A clock tick inside a note message leaves the message intact.
		med_pkg::CMD_NOTE_ON, 4'd1, 8'h3C, med_pkg::RT_CLOCK, 8'h40,
		// Highest bank, then start and stop.
		med_pkg::CMD_CTRL, 4'd0, 1'b0, med_pkg::CC_BANK, 8'h03,
		med_pkg::RT_START, med_pkg::RT_STOP,
		// SysEx start, its data byte is skipped.
		SYS_FIRST, 8'h12,
		// A new status abandons the note; no running status afterwards.
		med_pkg::CMD_NOTE_ON, 4'd0, 8'h40, med_pkg::CMD_NOTE_OFF, 4'd0, 8'h41, 8'h00
	};

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [7:0]                     s_tdata   = '0;
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [med_pkg::TDATA_BITS-1:0] m_tdata;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [2:0]                     cfg_index = '0;
	logic [3:0]                     cfg_data  = '0;

	// Predictor state and its copy of the registers.
	logic [3:0]      map_reg [med_pkg::MAP_REGS];
	logic [1:0]      vmode;
	med_pkg::phase_t ph;
	logic [3:0]      pend_cmd;
	logic [3:0]      pend_midi;
	logic [2:0]      pend_fm;
	logic [6:0]      data1;
	logic [2:0]      slot;
	logic [6:0]      nrpn_lo;
	logic [6:0]      nrpn_hi;
	logic [2:0]      uni_cnt;
	logic [4:0]      ticks;

	// Bytes waiting to be sent and events waiting to be seen.
	logic [7:0]       byte_q [$];
	med_pkg::result_t event_q [$];
	med_pkg::result_t seen_ev;
	med_pkg::result_t want_ev;
	int               mismatches   = 0;
	int               quiet_cycles = 0;
	int               src_idle     = 0;
	int               snk_idle     = 0;
	int               queued       = 0;
	bit               byte_taken   = 1'b0;
	bit               calm         = 1'b0;

	midi_event_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Work out the event that one MIDI byte causes and advance the parser state.
	function automatic med_pkg::result_t decode_byte(input logic [7:0] b);
		med_pkg::result_t r;
		int               hit;
		int               c;
		int               nn;
		int               mk;
		logic             master;
		logic [2:0]       s;
		logic [6:0]       v;
		r = '0;
		v = b[6:0];
		if (b[7]) begin
			if (b >= med_pkg::RT_FIRST) begin
				// Realtime bytes act at once and keep any pending message.
				if (b == med_pkg::RT_CLOCK) begin
					ticks = (ticks < med_pkg::TICK_MAX) ? ticks + 5'd1 : 5'd0;
					r.event_res = med_pkg::EV_CLOCK;
				end else if (b == med_pkg::RT_START) begin
					ticks = '0;
					r.event_res = med_pkg::EV_START;
				end else if (b == med_pkg::RT_STOP) begin
					r.event_res = med_pkg::EV_ALL_OFF;
				end
			end else begin
				ph = med_pkg::PH_WAIT;
				if (b[7:4] != med_pkg::CMD_SYSTEM) begin
					// Lowest FM channel whose map matches wins.
					hit = -1;
					for (c = med_pkg::MAP_SEARCH - 1; c >= 0; c--)
						if (map_reg[c] == b[3:0])
							hit = c;
					if (hit >= 0 && (b[7:4] == med_pkg::CMD_NOTE_OFF ||
							b[7:4] == med_pkg::CMD_NOTE_ON ||
							b[7:4] == med_pkg::CMD_CTRL ||
							b[7:4] == med_pkg::CMD_PROGRAM ||
							b[7:4] == med_pkg::CMD_BEND)) begin
						pend_cmd  = b[7:4];
						pend_midi = b[3:0];
						pend_fm   = hit[2:0];
						ph        = med_pkg::PH_DATA1;
					end
				end
			end
		end else if (ph == med_pkg::PH_DATA1) begin
			if (pend_cmd == med_pkg::CMD_PROGRAM) begin
				ph = med_pkg::PH_WAIT;
			end else begin
				data1 = v;
				ph    = med_pkg::PH_DATA2;
			end
		end else if (ph == med_pkg::PH_DATA2) begin
			ph     = med_pkg::PH_WAIT;
			master = (pend_midi == map_reg[0]);
			case (pend_cmd)
				med_pkg::CMD_NOTE_ON: begin
					if (vmode == med_pkg::VM_POLY) begin
						// Poly mode: rotate through the slots, master channel only.
						if (master) begin
							s    = (slot >= med_pkg::FM_CHANNELS) ? 3'd0 : slot;
							slot = (s + 3'd1 >= med_pkg::FM_CHANNELS) ? 3'd0 : s + 3'd1;
							r.event_res   = med_pkg::EV_PLAY;
							r.fm_channel  = s;
							r.note_number = data1;
							r.flash_mask  = 6'b1 << s;
						end
					end else if (vmode == med_pkg::VM_INDEP) begin
						r.event_res   = med_pkg::EV_PLAY;
						r.fm_channel  = pend_fm;
						r.note_number = data1;
						r.flash_mask  = 6'b1 << pend_fm;
					end else if (master) begin
						// Unison modes flash channels 0 up to the unison count plus one.
						mk = (1 << (int'(uni_cnt) + 2)) - 1;
						r.event_res   = med_pkg::EV_PLAY;
						r.note_number = data1;
						r.flash_mask  = mk[5:0];
					end
				end
				med_pkg::CMD_NOTE_OFF: begin
					if (vmode == med_pkg::VM_INDEP) begin
						r.event_res   = med_pkg::EV_RELEASE;
						r.fm_channel  = pend_fm;
						r.note_number = data1;
					end else if (master) begin
						r.event_res   = med_pkg::EV_RELEASE;
						r.fm_channel  = (vmode == med_pkg::VM_POLY) ? 3'd6 : 3'd0;
						r.note_number = data1;
					end
				end
				med_pkg::CMD_CTRL: begin
					r.fm_channel   = pend_fm;
					r.resend_patch = 1'b1;
					if (data1 == med_pkg::CC_BANK && v <= 7'd3) begin
						r.event_res   = med_pkg::EV_BANK;
						r.param_value = v;
					end
					if (data1 == med_pkg::CC_NRPN_LSB)
						nrpn_lo = v;
					if (data1 == med_pkg::CC_NRPN_MSB)
						nrpn_hi = v;
					if (data1 == med_pkg::CC_DATA && nrpn_hi == 7'd0) begin
						// Data entry: the parameter number picks the event and the value transform.
						nn = nrpn_lo;
						if (nn <= 4) begin
							r.event_res   = med_pkg::EV_CHAN_PAR;
							r.param_id    = nn[3:0];
							r.param_value = v & ((nn == 2 || nn == 4) ? 7'd3 : 7'd7);
						end else if (nn == 5) begin
							r.event_res   = med_pkg::EV_GLOB_PAR;
							r.param_id    = 4'd5;
							r.param_value = v & 7'd7;
						end else if (nn == 6) begin
							r.event_res   = med_pkg::EV_GLOB_PAR;
							r.param_id    = 4'd6;
							r.param_value = v & 7'd1;
						end else if (nn == 7) begin
							r.event_res   = med_pkg::EV_GLOB_PAR;
							r.param_id    = 4'd7;
							r.param_value = v >> 1;
						end else if (nn == NRPN_UNISON) begin
							if (v <= 7'd4) begin
								uni_cnt       = v[2:0];
								r.event_res   = med_pkg::EV_GLOB_PAR;
								r.param_id    = NRPN_UNISON[3:0];
								r.param_value = v;
							end
						end else if (nn >= 10 && nn < 50) begin
							c = (nn - 10) % 10;
							r.event_res      = med_pkg::EV_OP_PAR;
							r.param_id       = c[3:0];
							r.operator_index = 2'((nn - 10) / 10);
							r.param_value    = (c == 1) ? (v & 7'd1) : (v >> OP_SHR[3*c +: 3]);
						end
					end else if (data1 == med_pkg::CC_ALL_OFF) begin
						r.event_res = med_pkg::EV_ALL_OFF;
					end else if (data1 == med_pkg::CC_RESET_ALL) begin
						ticks = '0;
					end
				end
				med_pkg::CMD_BEND: begin
					r.event_res  = med_pkg::EV_BEND;
					r.fm_channel = pend_fm;
					r.bend_value = {~v[6], v[5:0], data1};
				end
				default: ;
			endcase
		end else begin
			ph = med_pkg::PH_WAIT;
		end
		r.clock_count = ticks;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch in %s: got %0h, expected %0h", what, got, want);
		mismatches++;
	endtask

	task automatic put(input logic [7:0] b);
		byte_q.push_back(b);
		queued++;
	endtask

	// A data byte, now and then preceded by a realtime byte.
	task automatic put_data(input logic [6:0] d);
		if ($urandom_range(0, 19) == 0)
			put(med_pkg::RT_FIRST + 8'($urandom_range(0, 7)));
		put({1'b0, d});
	endtask

	task automatic put_cc(input logic [3:0] ch, input logic [6:0] ctrl, input logic [6:0] val);
		put({med_pkg::CMD_CTRL, ch});
		put_data(ctrl);
		put_data(val);
	endtask

	// One random message: mostly well-formed, with noise and broken messages mixed in.
	task automatic add_message();
		int         kind;
		int         n;
		logic [3:0] ch;
		logic [6:0] ctrl;
		kind = $urandom_range(0, 99);
		if ($urandom_range(0, 4) == 0)
			ch = 4'($urandom_range(0, 15));
		else if ($urandom_range(0, 2) == 0)
			ch = map_reg[0];
		else
			ch = map_reg[$urandom_range(0, med_pkg::MAP_REGS - 1)];
		if (kind < 30) begin
			put({($urandom_range(0, 1) ? med_pkg::CMD_NOTE_ON : med_pkg::CMD_NOTE_OFF), ch});
			put_data(7'($urandom_range(0, 127)));
			put_data(7'($urandom_range(0, 127)));
		end else if (kind < 50) begin
			// Parameter write: select the number, then enter the data.
			if ($urandom_range(0, 7) != 0)
				put_cc(ch, med_pkg::CC_NRPN_MSB,
					($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) : 7'd0);
			if ($urandom_range(0, 7) != 0)
				put_cc(ch, med_pkg::CC_NRPN_LSB, ($urandom_range(0, 9) == 0) ?
					7'($urandom_range(0, 127)) : 7'($urandom_range(0, 51)));
			put_cc(ch, med_pkg::CC_DATA, ($urandom_range(0, 2) == 0) ?
				7'($urandom_range(0, 6)) : 7'($urandom_range(0, 127)));
		end else if (kind < 62) begin
			case ($urandom_range(0, 6))
				0:       ctrl = med_pkg::CC_BANK;
				1:       ctrl = med_pkg::CC_ALL_OFF;
				2:       ctrl = med_pkg::CC_RESET_ALL;
				3:       ctrl = med_pkg::CC_NRPN_LSB;
				4:       ctrl = med_pkg::CC_NRPN_MSB;
				5:       ctrl = med_pkg::CC_DATA;
				default: ctrl = 7'($urandom_range(0, 127));
			endcase
			put_cc(ch, ctrl, (ctrl == med_pkg::CC_BANK) ?
				7'($urandom_range(0, 7)) : 7'($urandom_range(0, 127)));
		end else if (kind < 70) begin
			put({med_pkg::CMD_BEND, ch});
			put_data(7'($urandom_range(0, 127)));
			put_data(7'($urandom_range(0, 127)));
		end else if (kind < 75) begin
			// Program change takes one byte; a second one is stray.
			put({med_pkg::CMD_PROGRAM, ch});
			put_data(7'($urandom_range(0, 127)));
			if ($urandom_range(0, 1))
				put_data(7'($urandom_range(0, 127)));
		end else if (kind < 85) begin
			if ($urandom_range(0, 1)) begin
				n = $urandom_range(1, 30);
				repeat (n) put(med_pkg::RT_CLOCK);
			end else begin
				put(med_pkg::RT_FIRST + 8'($urandom_range(0, 7)));
			end
		end else if (kind < 92) begin
			n = $urandom_range(1, 4);
			repeat (n) put(8'($urandom_range(0, 255)));
		end else begin
			case ($urandom_range(0, 2))
				0: begin
					// A message cut short by whatever comes next.
					put({4'($urandom_range(8, 14)), ch});
					if ($urandom_range(0, 1))
						put_data(7'($urandom_range(0, 127)));
				end
				1: begin
					put(SYS_FIRST + 8'($urandom_range(0, 7)));
					n = $urandom_range(1, 3);
					repeat (n) put_data(7'($urandom_range(0, 127)));
				end
				default: begin
					put({($urandom_range(0, 1) ? CMD_POLY_AT : CMD_CHAN_AT), ch});
					put_data(7'($urandom_range(0, 127)));
					put_data(7'($urandom_range(0, 127)));
				end
			endcase
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [3:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx < med_pkg::MAP_REGS)
			map_reg[idx] = val;
		else if (idx == med_pkg::REG_VOICE_MODE)
			vmode = val[1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (byte_q.size() != 0 || s_tvalid || event_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Stimulus: reset, opening stream, then one random phase per register setting.
	initial begin
		int         p;
		int         i;
		logic [3:0] mv [med_pkg::MAP_REGS];
		logic [1:0] vm;
		for (i = 0; i < med_pkg::MAP_REGS; i++)
			map_reg[i] = 4'(i);
		vmode    = med_pkg::VM_INDEP;
		ph       = med_pkg::PH_WAIT;
		pend_cmd = '0;
		pend_midi = '0;
		pend_fm  = '0;
		data1    = '0;
		slot     = '0;
		nrpn_lo  = '0;
		nrpn_hi  = 7'd1;
		uni_cnt  = '0;
		ticks    = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (i = 0; i < OPEN_LEN; i++)
			put(OPENING[8*(OPEN_LEN-1-i) +: 8]);
		for (p = 0; p < PHASES; p++) begin
			// The sender holds off until every event is back, then the registers change.
			wait_drained();
			case (p)
				0: begin
					for (i = 0; i < med_pkg::MAP_REGS; i++) mv[i] = 4'(i);
					vm = med_pkg::VM_POLY;
				end
				1: begin
					for (i = 0; i < med_pkg::MAP_REGS; i++) mv[i] = 4'hF;
					vm = VM_UNISON;
				end
				2: begin
					for (i = 0; i < med_pkg::MAP_REGS; i++) mv[i] = 4'h0;
					vm = VM_UNI_MULTI;
				end
				3: begin
					for (i = 0; i < med_pkg::MAP_REGS; i++) mv[i] = 4'($urandom_range(0, 3));
					vm = med_pkg::VM_INDEP;
				end
				default: begin
					for (i = 0; i < med_pkg::MAP_REGS; i++) mv[i] = 4'($urandom_range(0, 15));
					vm = 2'($urandom_range(0, 3));
				end
			endcase
			for (i = 0; i < med_pkg::MAP_REGS; i++)
				write_reg(med_pkg::REG_MAP_0 + 3'(i), mv[i]);
			write_reg(med_pkg::REG_VOICE_MODE, {2'b00, vm});
			if (p == 0)
				write_reg(REG_SPARE, 4'($urandom_range(0, 15)));
			if (p == PHASES - 1)
				calm = 1'b1;
			queued = 0;
			while (queued < PHASE_ITEMS)
				add_message();
		end
		wait_drained();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Byte driver: presents the oldest pending byte, with random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || byte_taken) begin
			byte_taken = 1'b0;
			if (src_idle > 0) begin
				src_idle--;
				s_tvalid <= 1'b0;
			end else if (byte_q.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				src_idle = $urandom_range(0, 15);
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata  <= byte_q[0];
			end
		end
	end

	// Event sink: ready most of the time, with random stall bursts.
	always @(negedge clk) begin
		if (snk_idle > 0) begin
			snk_idle--;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			snk_idle = $urandom_range(0, 15);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Monitor: predicts each accepted byte, checks each event and watches for a hang.
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			event_q.push_back(decode_byte(s_tdata));
			byte_q.delete(0);
			byte_taken = 1'b1;
		end
		if (m_tvalid && m_tready) begin
			seen_ev = m_tdata[med_pkg::RES_BITS-1:0];
			if (m_tdata[med_pkg::TDATA_BITS-1:med_pkg::RES_BITS] !== '0)
				report_mismatch("padding", m_tdata[med_pkg::TDATA_BITS-1:med_pkg::RES_BITS], 0);
			if (event_q.size() == 0) begin
				report_mismatch("item with nothing expected", seen_ev, 0);
			end else begin
				want_ev = event_q.pop_front();
				if (seen_ev.event_res !== want_ev.event_res)
					report_mismatch("event_res", seen_ev.event_res, want_ev.event_res);
				if (seen_ev.fm_channel !== want_ev.fm_channel)
					report_mismatch("fm_channel", seen_ev.fm_channel, want_ev.fm_channel);
				if (seen_ev.note_number !== want_ev.note_number)
					report_mismatch("note_number", seen_ev.note_number, want_ev.note_number);
				if (seen_ev.flash_mask !== want_ev.flash_mask)
					report_mismatch("flash_mask", seen_ev.flash_mask, want_ev.flash_mask);
				if (seen_ev.resend_patch !== want_ev.resend_patch)
					report_mismatch("resend_patch", seen_ev.resend_patch, want_ev.resend_patch);
				if (seen_ev.param_id !== want_ev.param_id)
					report_mismatch("param_id", seen_ev.param_id, want_ev.param_id);
				if (seen_ev.operator_index !== want_ev.operator_index)
					report_mismatch("operator_index", seen_ev.operator_index,
						want_ev.operator_index);
				if (seen_ev.param_value !== want_ev.param_value)
					report_mismatch("param_value", seen_ev.param_value, want_ev.param_value);
				if (seen_ev.bend_value !== want_ev.bend_value)
					report_mismatch("bend_value", seen_ev.bend_value, want_ev.bend_value);
				if (seen_ev.clock_count !== want_ev.clock_count)
					report_mismatch("clock_count", seen_ev.clock_count, want_ev.clock_count);
			end
		end
		// Any handshake on any channel counts as progress.
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

endmodule
